>>> src/smamt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package smamt_pkg;

   // Command codes
   localparam logic [2:0] CMD_LOAD_A    = 3'd0;
   localparam logic [2:0] CMD_LOAD_B    = 3'd1;
   localparam logic [2:0] CMD_ADD       = 3'd2;
   localparam logic [2:0] CMD_MULT      = 3'd3;
   localparam logic [2:0] CMD_TRANSPOSE = 3'd4;

   // Status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_MISMATCH = 2'd1;
   localparam logic [1:0] ST_RANGE    = 2'd2;

   // Register indexes
   localparam logic [1:0] REG_A_ROWS = 2'd0;
   localparam logic [1:0] REG_A_COLS = 2'd1;
   localparam logic [1:0] REG_B_ROWS = 2'd2;
   localparam logic [1:0] REG_B_COLS = 2'd3;

   localparam int FRAC_BITS = 16;
   localparam int ACC_WIDTH = 128;

   typedef enum logic [3:0] {
      S_IDLE,
      S_ADD_RD,     // read A and B entries
      S_ADD_WR,     // write saturated sum to A
      S_MUL_RD,     // read A[i][k], B[k][j]
      S_MUL_MAC,    // multiply and accumulate
      S_MUL_WR,     // round, saturate, write product store
      S_CPY_RD,     // read product store
      S_CPY_WR,     // write back into A
      S_TR_RD,      // read A for transpose
      S_TR_WR,      // write product store transposed
      S_EMIT_RD,    // read A for output
      S_EMIT_OUT,   // hold result item until taken
      S_ERR         // single status item
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic       rd_a;
      logic       rd_b;
      logic       rd_p;
      logic       mul;       // multiply addressing: A[i][k], B[k][j]
      logic       wr_a_sum;
      logic       wr_a_p;
      logic       wr_p_acc;
      logic       wr_p_a;
      logic       acc_clr;
      logic       acc_en;
      logic       load_out;
      logic [2:0] i;
      logic [2:0] j;
      logic [2:0] k;
   } ctrl_type;

endpackage
`default_nettype wire

>>> src/smamt_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module smamt_datapath
   import smamt_pkg::*;
#(
   parameter int MAX_DIM     = 8,
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic                   clock,
   input  wire ctrl_type               ctrl,
   input  wire logic                   load_wr_a,
   input  wire logic                   load_wr_b,
   input  wire logic [2:0]             load_row,
   input  wire logic [2:0]             load_col,
   input  wire logic [31:0]            load_value,
   output logic      [31:0]            out_value
);
   localparam int IDX_W = $clog2(MAX_DIM);
   localparam int ADDR_W = 2 * IDX_W;
   localparam int CELLS = 1 << ADDR_W;
   localparam int VW = VALUE_WIDTH;
   localparam int PW = 2 * VW;

   localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
   localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};

   logic signed [VW-1:0] mem_a [CELLS];
   logic signed [VW-1:0] mem_b [CELLS];
   logic signed [VW-1:0] mem_p [CELLS];

   logic signed [VW-1:0] a_q_ff, b_q_ff, p_q_ff;
   logic signed [PW-1:0] prod_ff;
   logic                 prod_v_ff;
   logic signed [ACC_WIDTH-1:0] acc_ff, acc_in;
   logic [31:0]          out_ff;

   function automatic logic [ADDR_W-1:0] addr(input logic [2:0] r, input logic [2:0] c);
      addr = {r[IDX_W-1:0], c[IDX_W-1:0]};
   endfunction

   // Sign extension and saturation of a loaded value
   logic signed [63:0] ld_ext;
   logic signed [VW-1:0] ld_sat;
   always_comb begin
      ld_ext = 64'(signed'(load_value));
      if (ld_ext > 64'(VMAX))      ld_sat = VMAX;
      else if (ld_ext < 64'(VMIN)) ld_sat = VMIN;
      else                         ld_sat = VW'(ld_ext);
   end

   // Saturated sum
   logic signed [VW:0]   sum;
   logic signed [VW-1:0] sum_sat;
   always_comb begin
      sum = (VW+1)'(a_q_ff) + (VW+1)'(b_q_ff);
      if (sum > (VW+1)'(VMAX))      sum_sat = VMAX;
      else if (sum < (VW+1)'(VMIN)) sum_sat = VMIN;
      else                          sum_sat = VW'(sum);
   end

   // Round to nearest (ties up), shift, saturate
   logic signed [ACC_WIDTH-1:0] rnd;
   logic signed [ACC_WIDTH-1:0] shr;
   logic signed [VW-1:0]        rnd_sat;
   always_comb begin
      rnd = acc_ff + ACC_WIDTH'(1 << (FRAC_BITS - 1));
      shr = rnd >>> FRAC_BITS;
      if (shr > ACC_WIDTH'(VMAX))      rnd_sat = VMAX;
      else if (shr < ACC_WIDTH'(VMIN)) rnd_sat = VMIN;
      else                             rnd_sat = VW'(shr);
   end

   // Accumulator: one product registered, then added
   always_comb begin
      acc_in = acc_ff;
      if (ctrl.acc_clr)                 acc_in = '0;
      else if (prod_v_ff)               acc_in = acc_ff + ACC_WIDTH'(prod_ff);
   end

   // Memories
   always_ff @(posedge clock) begin
      if (load_wr_a)      mem_a[addr(load_row, load_col)] <= ld_sat;
      else if (ctrl.wr_a_sum) mem_a[addr(ctrl.i, ctrl.j)] <= sum_sat;
      else if (ctrl.wr_a_p)   mem_a[addr(ctrl.i, ctrl.j)] <= p_q_ff;
      if (load_wr_b)      mem_b[addr(load_row, load_col)] <= ld_sat;
      if (ctrl.wr_p_acc)  mem_p[addr(ctrl.i, ctrl.j)] <= rnd_sat;
      else if (ctrl.wr_p_a) mem_p[addr(ctrl.j, ctrl.i)] <= a_q_ff;
      if (ctrl.rd_a) a_q_ff <= mem_a[addr(ctrl.i, ctrl.mul ? ctrl.k : ctrl.j)];
      if (ctrl.rd_b) b_q_ff <= mem_b[addr(ctrl.mul ? ctrl.k : ctrl.i, ctrl.j)];
      if (ctrl.rd_p) p_q_ff <= mem_p[addr(ctrl.i, ctrl.j)];
      // result item value straight from A
      if (ctrl.load_out) out_ff <= 32'(mem_a[addr(ctrl.i, ctrl.j)]);
   end

   // Multiplier and accumulator registers
   always_ff @(posedge clock) begin
      prod_ff   <= PW'(a_q_ff) * PW'(b_q_ff);
      prod_v_ff <= ctrl.acc_en;
      acc_ff    <= acc_in;
   end

   assign out_value = out_ff;
endmodule
`default_nettype wire

>>> src/smamt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module smamt_ctrl
   import smamt_pkg::*;
#(
   parameter int MAX_DIM = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [3:0]  csr_wdata,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [2:0]  cmd,
   input  wire logic [2:0]  row,
   input  wire logic [2:0]  col,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [1:0]       status,
   output logic [2:0]       out_row,
   output logic [2:0]       out_col,
   output logic             last,
   output logic             load_wr_a,
   output logic             load_wr_b,
   output ctrl_type         ctrl
);
   localparam logic [3:0] DMAX = 4'(MAX_DIM);

   state_type state_ff, state_in;
   logic [3:0] ar_ff, ac_ff, br_ff, bc_ff;
   logic [3:0] rows_ff, rows_in, cols_ff, cols_in;
   logic [2:0] i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [1:0] st_ff, st_in;
   logic [2:0] drain_ff, drain_in;

   function automatic logic [3:0] clampd(input logic [3:0] d);
      if (d == 4'd0)    clampd = 4'd1;
      else if (d > DMAX) clampd = DMAX;
      else               clampd = d;
   endfunction

   logic [3:0] car, cac, cbr, cbc;
   logic       accept, i_end, j_end, k_end, emit_last;
   logic [3:0] jlim;
   assign car = clampd(ar_ff);
   assign cac = clampd(ac_ff);
   assign cbr = clampd(br_ff);
   assign cbc = clampd(bc_ff);
   assign accept = req_tvalid && req_tready;
   assign i_end = ({1'b0, i_ff} == rows_ff - 4'd1);
   assign j_end = ({1'b0, j_ff} == jlim - 4'd1);
   assign k_end = ({1'b0, k_ff} == cols_ff - 4'd1);
   assign emit_last = i_end && ({1'b0, j_ff} == cols_ff - 4'd1);

   // Column bound of the current sweep
   always_comb begin
      unique case (state_ff)
         S_MUL_RD, S_MUL_MAC, S_MUL_WR: jlim = cbc;
         default:                       jlim = cols_ff;
      endcase
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      rows_in  = rows_ff;
      cols_in  = cols_ff;
      i_in = i_ff; j_in = j_ff; k_in = k_ff;
      st_in = st_ff;
      drain_in = drain_ff;
      load_wr_a = 1'b0;
      load_wr_b = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            i_in = '0; j_in = '0; k_in = '0;
            if (accept) begin
               case (cmd)
                  CMD_LOAD_A: begin
                     if ({1'b0, row} >= car || {1'b0, col} >= cac) begin
                        st_in = ST_RANGE; state_in = S_ERR;
                     end else begin
                        load_wr_a = 1'b1; rows_in = car; cols_in = cac;
                     end
                  end
                  CMD_LOAD_B: begin
                     if ({1'b0, row} >= cbr || {1'b0, col} >= cbc) begin
                        st_in = ST_RANGE; state_in = S_ERR;
                     end else begin
                        load_wr_b = 1'b1;
                     end
                  end
                  CMD_ADD: begin
                     if (cbr != rows_ff || cbc != cols_ff) begin
                        st_in = ST_MISMATCH; state_in = S_ERR;
                     end else state_in = S_ADD_RD;
                  end
                  CMD_MULT: begin
                     if (cbr != cols_ff) begin
                        st_in = ST_MISMATCH; state_in = S_ERR;
                     end else state_in = S_MUL_RD;
                  end
                  CMD_TRANSPOSE: state_in = S_TR_RD;
                  default: ;
               endcase
            end
         end
         S_ADD_RD:  state_in = S_ADD_WR;
         S_ADD_WR, S_TR_WR, S_CPY_WR: begin
            if (j_end) begin
               j_in = '0;
               if (i_end) begin
                  i_in = '0;
                  state_in = S_EMIT_RD;
                  if (state_ff == S_TR_WR) begin
                     state_in = S_CPY_RD;
                     rows_in = cols_ff; cols_in = rows_ff;
                  end
               end else i_in = i_ff + 3'd1;
            end else j_in = j_ff + 3'd1;
            if (!(j_end && i_end)) begin
               unique case (state_ff)
                  S_ADD_WR: state_in = S_ADD_RD;
                  S_TR_WR:  state_in = S_TR_RD;
                  default:  state_in = S_CPY_RD;
               endcase
            end
         end
         S_TR_RD: state_in = S_TR_WR;
         S_MUL_RD: state_in = S_MUL_MAC;
         S_MUL_MAC: begin
            if (k_end) begin
               k_in = '0; drain_in = 3'd3; state_in = S_MUL_WR;
            end else begin
               k_in = k_ff + 3'd1; state_in = S_MUL_RD;
            end
         end
         S_MUL_WR: begin
            // wait for the product pipeline to drain into the accumulator
            if (drain_ff != 3'd0) drain_in = drain_ff - 3'd1;
            else begin
               if (j_end) begin
                  j_in = '0;
                  if (i_end) begin
                     // A takes the column count of B for the copy-back
                     i_in = '0; state_in = S_CPY_RD; cols_in = cbc;
                  end else begin
                     i_in = i_ff + 3'd1; state_in = S_MUL_RD;
                  end
               end else begin
                  j_in = j_ff + 3'd1; state_in = S_MUL_RD;
               end
            end
         end
         S_CPY_RD: state_in = S_CPY_WR;
         S_EMIT_RD: state_in = S_EMIT_OUT;
         S_EMIT_OUT: begin
            if (rsp_tready) begin
               if (emit_last) begin
                  state_in = S_IDLE;
               end else begin
                  state_in = S_EMIT_RD;
                  if ({1'b0, j_ff} == cols_ff - 4'd1) begin
                     j_in = '0; i_in = i_ff + 3'd1;
                  end else j_in = j_ff + 3'd1;
               end
            end
         end
         S_ERR: if (rsp_tready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // Datapath commands
   always_comb begin
      ctrl = '0;
      ctrl.i = i_ff; ctrl.j = j_ff; ctrl.k = k_ff;
      unique case (state_ff)
         S_ADD_RD:  begin ctrl.rd_a = 1'b1; ctrl.rd_b = 1'b1; end
         S_ADD_WR:  ctrl.wr_a_sum = 1'b1;
         S_MUL_RD:  begin ctrl.rd_a = 1'b1; ctrl.rd_b = 1'b1; ctrl.acc_en = 1'b0;
                          ctrl.mul = 1'b1;
                          ctrl.acc_clr = (k_ff == 3'd0); end
         S_MUL_MAC: ctrl.acc_en = 1'b1;
         S_MUL_WR:  ctrl.wr_p_acc = (drain_ff == 3'd0);
         S_CPY_RD:  ctrl.rd_p = 1'b1;
         S_CPY_WR:  ctrl.wr_a_p = 1'b1;
         S_TR_RD:   ctrl.rd_a = 1'b1;
         S_TR_WR:   ctrl.wr_p_a = 1'b1;
         S_EMIT_RD: ctrl.load_out = 1'b1;
         default: ;
      endcase
   end

   // Output and handshake
   always_comb begin
      req_tready = (state_ff == S_IDLE);
      rsp_tvalid = (state_ff == S_EMIT_OUT) || (state_ff == S_ERR);
      status  = (state_ff == S_ERR) ? st_ff : ST_OK;
      out_row = (state_ff == S_ERR) ? 3'd0 : i_ff;
      out_col = (state_ff == S_ERR) ? 3'd0 : j_ff;
      last    = (state_ff == S_ERR) ? 1'b1 : emit_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ar_ff <= 4'd8; ac_ff <= 4'd8; br_ff <= 4'd8; bc_ff <= 4'd8;
         rows_ff <= DMAX; cols_ff <= DMAX;
         i_ff <= '0; j_ff <= '0; k_ff <= '0;
         st_ff <= ST_OK; drain_ff <= '0;
      end else begin
         state_ff <= state_in;
         rows_ff <= rows_in; cols_ff <= cols_in;
         i_ff <= i_in; j_ff <= j_in; k_ff <= k_in;
         st_ff <= st_in; drain_ff <= drain_in;
         if (csr_we) begin
            unique case (csr_index)
               REG_A_ROWS: ar_ff <= csr_wdata;
               REG_A_COLS: ac_ff <= csr_wdata;
               REG_B_ROWS: br_ff <= csr_wdata;
               REG_B_COLS: bc_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end
endmodule
`default_nettype wire

>>> src/small_matrix_add_mult_transpose_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Matrix unit holding A and B (up to MAX_DIM square, Q16.16). A load
// returns nothing unless out of range. Add reads each pair of elements and
// writes the saturated sum to A; transpose writes A transposed into the
// product store, then copies it back into A; multiply sums each product
// element through one multiplier and then copies back, with single-port
// reads of each store; then each result item of A is sent in turn.
// One item is worked at a time; req_tready is high only while the unit is idle.
module small_matrix_add_mult_transpose_core
   import smamt_pkg::*;
#(
   parameter int MAX_DIM     = 8,
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [3:0]  csr_wdata,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,   // command[2:0], row[5:3], col[8:6], value[40:9]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // status[1:0], out_row[4:2], out_col[7:5], out_value[39:8]
   output logic             rsp_tlast
);
   ctrl_type    ctrl;
   logic        load_wr_a, load_wr_b;
   logic [1:0]  status;
   logic [2:0]  out_row, out_col;
   logic [31:0] out_value;

   smamt_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
      .clock, .reset, .csr_we, .csr_index, .csr_wdata,
      .req_tvalid, .req_tready,
      .cmd(req_tdata[2:0]), .row(req_tdata[5:3]), .col(req_tdata[8:6]),
      .rsp_tvalid, .rsp_tready, .status, .out_row, .out_col,
      .last(rsp_tlast), .load_wr_a, .load_wr_b, .ctrl
   );

   smamt_datapath #(.MAX_DIM(MAX_DIM), .VALUE_WIDTH(VALUE_WIDTH)) u_dp (
      .clock, .ctrl, .load_wr_a, .load_wr_b,
      .load_row(req_tdata[5:3]), .load_col(req_tdata[8:6]),
      .load_value(req_tdata[40:9]), .out_value
   );

   // status items carry a zero value
   assign rsp_tdata = {(status == ST_OK) ? out_value : 32'd0, out_col, out_row, status};

   // No new item while results are pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("ready while result pending");
   // Error items always close the command
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[1:0] != ST_OK) |-> rsp_tlast)
      else $error("error item without last");
   // Loads into A never produce ok results
   a_load_quiet: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tdata[2:0] == CMD_LOAD_A) |=>
      (!rsp_tvalid || rsp_tdata[1:0] == ST_RANGE)) else $error("load emitted data");
endmodule
`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 1ps
module tb;
   import smamt_pkg::*;

   typedef struct packed {
      logic [1:0]  status;
      logic [2:0]  out_row;
      logic [2:0]  out_col;
      logic [31:0] out_value;
      logic        last;
   } result_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [3:0]  csr_wdata = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        rsp_tlast;

   small_matrix_add_mult_transpose_core dut (.*);

   always #10 clock = ~clock;

   // shadow state of the unit
   logic signed [31:0] mat_a [64];
   logic signed [31:0] mat_b [64];
   bit                 b_written [64];
   int unsigned        a_rows_cfg, a_cols_cfg, b_rows_cfg, b_cols_cfg;
   int unsigned        rows_now, cols_now;
   result_t            expected_q [$];

   int  errors = 0;
   int  idle_pct = 30;      // sender / receiver idle percentage
   bit  hold_rsp = 1'b0;
   int  quiet_cycles = 0;

   function automatic int unsigned clamp_dim(int unsigned d);
      if (d < 1) return 1;
      if (d > 8) return 8;
      return d;
   endfunction

   function automatic logic signed [31:0] sat32(logic signed [127:0] v);
      if (v > 128'sd2147483647) return 32'sh7fffffff;
      if (v < -128'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic void push_status(logic [1:0] st);
      result_t r;
      r = '{st, 3'd0, 3'd0, 32'd0, 1'b1};
      expected_q.push_back(r);
   endfunction

   function automatic void push_matrix_a();
      result_t r;
      for (int i = 0; i < rows_now; i++)
         for (int j = 0; j < cols_now; j++) begin
            r = '{ST_OK, i[2:0], j[2:0], mat_a[i*8+j],
                  (i == rows_now - 1) && (j == cols_now - 1)};
            expected_q.push_back(r);
         end
   endfunction

   // predict the results of one command
   function automatic void predict_matrix_op(logic [2:0] cmd, logic [2:0] row,
                                             logic [2:0] col, logic signed [31:0] val);
      int unsigned br, bc, ar, ac;
      logic signed [31:0]  prod [64];
      logic signed [127:0] acc;
      br = clamp_dim(b_rows_cfg);
      bc = clamp_dim(b_cols_cfg);
      case (cmd)
         CMD_LOAD_A: begin
            ar = clamp_dim(a_rows_cfg);
            ac = clamp_dim(a_cols_cfg);
            if (row >= ar || col >= ac) push_status(ST_RANGE);
            else begin
               rows_now = ar;
               cols_now = ac;
               mat_a[row*8+col] = val;
            end
         end
         CMD_LOAD_B: begin
            if (row >= br || col >= bc) push_status(ST_RANGE);
            else begin
               mat_b[row*8+col] = val;
               b_written[row*8+col] = 1'b1;
            end
         end
         CMD_ADD: begin
            if (br != rows_now || bc != cols_now) push_status(ST_MISMATCH);
            else begin
               for (int i = 0; i < rows_now; i++)
                  for (int j = 0; j < cols_now; j++)
                     mat_a[i*8+j] = sat32(128'(mat_a[i*8+j]) + 128'(mat_b[i*8+j]));
               push_matrix_a();
            end
         end
         CMD_MULT: begin
            if (br != cols_now) push_status(ST_MISMATCH);
            else begin
               for (int i = 0; i < rows_now; i++)
                  for (int j = 0; j < bc; j++) begin
                     acc = '0;
                     for (int k = 0; k < cols_now; k++)
                        acc += 128'(mat_a[i*8+k]) * 128'(mat_b[k*8+j]);
                     acc = (acc + 128'sd32768) >>> 16;
                     prod[i*8+j] = sat32(acc);
                  end
               for (int i = 0; i < rows_now; i++)
                  for (int j = 0; j < bc; j++)
                     mat_a[i*8+j] = prod[i*8+j];
               cols_now = bc;
               push_matrix_a();
            end
         end
         CMD_TRANSPOSE: begin
            for (int i = 0; i < rows_now; i++)
               for (int j = 0; j < cols_now; j++)
                  prod[j*8+i] = mat_a[i*8+j];
            ar = rows_now;
            rows_now = cols_now;
            cols_now = ar;
            for (int i = 0; i < rows_now; i++)
               for (int j = 0; j < cols_now; j++)
                  mat_a[i*8+j] = prod[i*8+j];
            push_matrix_a();
         end
         default: ;
      endcase
   endfunction

   // send one item, predicting at acceptance; valid stays up for a
   // following item and drops on an idle cycle or in drain
   task automatic send_item(logic [2:0] cmd, logic [2:0] row, logic [2:0] col,
                            logic [31:0] val);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, val, col, row, cmd};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_matrix_op(cmd, row, col, val);
   endtask

   // wait for all results, then a settle gap
   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, int unsigned v);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v[3:0];
      @(posedge clock);
      case (idx)
         REG_A_ROWS: a_rows_cfg = v;
         REG_A_COLS: a_cols_cfg = v;
         REG_B_ROWS: b_rows_cfg = v;
         default:    b_cols_cfg = v;
      endcase
   endtask

   task automatic set_dims(int unsigned ar, int unsigned ac, int unsigned br,
                           int unsigned bc);
      drain();
      write_reg(REG_A_ROWS, ar);
      write_reg(REG_A_COLS, ac);
      write_reg(REG_B_ROWS, br);
      write_reg(REG_B_COLS, bc);
      csr_we <= 1'b0;
   endtask

   function automatic logic [31:0] rand_value();
      case ($urandom_range(5))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return $urandom;
         default: return $urandom_range(32'h3ffff) - 32'h1ffff;
      endcase
   endfunction

   // fill A and B completely at current sizes (keeps reads defined)
   task automatic fill_all(bit extremes);
      logic [31:0] v;
      for (int i = 0; i < clamp_dim(a_rows_cfg); i++)
         for (int j = 0; j < clamp_dim(a_cols_cfg); j++) begin
            v = extremes ? ((i + j) % 2 ? 32'h7fffffff : 32'h80000000) : rand_value();
            send_item(CMD_LOAD_A, 3'(i), 3'(j), v);
         end
      for (int i = 0; i < clamp_dim(b_rows_cfg); i++)
         for (int j = 0; j < clamp_dim(b_cols_cfg); j++) begin
            v = extremes ? ((i + j) % 2 ? 32'h80000000 : 32'h7fffffff) : rand_value();
            send_item(CMD_LOAD_B, 3'(i), 3'(j), v);
         end
   endtask

   // true when every B entry needed by add/mult was written
   function automatic bit b_ready();
      for (int i = 0; i < 8; i++)
         for (int j = 0; j < 8; j++)
            if (i < clamp_dim(b_rows_cfg) && j < clamp_dim(b_cols_cfg) && !b_written[i*8+j])
               return 0;
      return 1;
   endfunction

   // directed: errors, ignored commands, extremes at small sizes
   task automatic test_directed();
      set_dims(2, 2, 2, 2);
      send_item(CMD_LOAD_A, 3'd7, 3'd0, 32'h1);    // out of range row
      send_item(CMD_LOAD_B, 3'd0, 3'd7, 32'h1);    // out of range col
      send_item(3'd5, 3'd7, 3'd7, 32'hffffffff);   // ignored commands
      send_item(3'd7, 3'd0, 3'd0, 32'h0);
      fill_all(1);
      send_item(CMD_ADD, 3'd0, 3'd0, 32'd0);       // add of opposite extremes
      send_item(CMD_MULT, 3'd0, 3'd0, 32'd0);      // multiply by extreme B
      send_item(CMD_TRANSPOSE, 3'd0, 3'd0, 32'd0);
      set_dims(2, 2, 3, 2);
      send_item(CMD_ADD, 3'd0, 3'd0, 32'd0);       // size mismatch
      send_item(CMD_MULT, 3'd0, 3'd0, 32'd0);
   endtask

   // random: well-formed sequences plus noise over several sizes
   task automatic test_random(int n_items, int unsigned maxd, int unsigned ar,
                              int unsigned ac, int unsigned br, int unsigned bc);
      int sent;
      int unsigned pick;
      set_dims(ar, ac, br, bc);
      for (int i = 0; i < 64; i++) b_written[i] = 0;
      fill_all(0);
      sent = 0;
      while (sent < n_items) begin
         pick = $urandom_range(99);
         if (pick < 40)
            send_item(CMD_LOAD_A, 3'($urandom_range(maxd)), 3'($urandom_range(maxd)),
                      rand_value());
         else if (pick < 70)
            send_item(CMD_LOAD_B, 3'($urandom_range(maxd)), 3'($urandom_range(maxd)),
                      rand_value());
         else if (pick < 80 && b_ready())
            send_item(CMD_ADD, 3'($urandom), 3'($urandom), $urandom);
         else if (pick < 90 && b_ready())
            send_item(CMD_MULT, 3'($urandom), 3'($urandom), $urandom);
         else if (pick < 97)
            send_item(CMD_TRANSPOSE, 3'($urandom), 3'($urandom), $urandom);
         else
            send_item(3'(3'd5 + $urandom_range(2)), 3'($urandom), 3'($urandom), $urandom);
         sent++;
      end
   endtask

   // receiver holds off while the sender keeps offering
   task automatic test_backpressure();
      set_dims(3, 3, 3, 3);
      hold_rsp = 1'b1;
      fill_all(0);
      send_item(CMD_TRANSPOSE, 3'd0, 3'd0, 32'd0);
      send_item(CMD_ADD, 3'd0, 3'd0, 32'd0);
      send_item(CMD_MULT, 3'd0, 3'd0, 32'd0);
      hold_rsp = 1'b0;
   endtask

   // result checker
   always @(posedge clock) begin
      result_t got, exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[1:0], rsp_tdata[4:2], rsp_tdata[7:5], rsp_tdata[39:8], rsp_tlast};
         if (expected_q.size() == 0) begin
            $display("%0t unexpected result: expected none, actual %h", $time, got);
            errors++;
         end else begin
            exp_r = expected_q.pop_front();
            if (got.status !== exp_r.status || got.out_row !== exp_r.out_row ||
                got.out_col !== exp_r.out_col || got.out_value !== exp_r.out_value ||
                got.last !== exp_r.last) begin
               $display("%0t result: expected st=%0d r=%0d c=%0d v=%h l=%0d",
                        $time, exp_r.status, exp_r.out_row, exp_r.out_col,
                        exp_r.out_value, exp_r.last);
               $display("%0t          actual   st=%0d r=%0d c=%0d v=%h l=%0d",
                        $time, got.status, got.out_row, got.out_col,
                        got.out_value, got.last);
               errors++;
            end
         end
      end
   end

   // receiver readiness, with a long counted hold-off when asked
   int hold_count = 0;
   always @(posedge clock) begin
      if (hold_rsp && hold_count < 3000) begin
         hold_count <= hold_count + 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= idle_pct);
      end
   end

   // watchdog on cycles with no accepted item
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 20000) begin
         $display("small_matrix_add_mult_transpose_core: mismatch");
         $finish;
      end
   end

   initial begin
      a_rows_cfg = 8; a_cols_cfg = 8; b_rows_cfg = 8; b_cols_cfg = 8;
      rows_now = 8; cols_now = 8;
      for (int i = 0; i < 64; i++) b_written[i] = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_backpressure();
      idle_pct = 0;                    // stretch with no idling
      test_random(30, 3, 3, 3, 3, 3);
      idle_pct = 30;
      test_random(40, 2, 2, 3, 3, 2);
      test_random(30, 1, 1, 1, 1, 1);
      test_random(20, 4, 4, 2, 2, 4);
      test_random(5, 7, 8, 8, 8, 8);
      test_random(5, 7, 0, 15, 0, 15);  // values outside 1..8 clamp
      drain();
      if (errors == 0 && expected_q.size() == 0)
         $display("small_matrix_add_mult_transpose_core: match");
      else
         $display("small_matrix_add_mult_transpose_core: mismatch");
      $finish;
   end

endmodule
